@@ src/bfaq_pkg.sv @@
// Shared constants, types and hash functions for the Bloom filter block.
package bfaq_pkg;

  localparam int FILTER_BITS = 65536;
  localparam int MAX_HASHES  = 16;
  localparam int STORE_BYTES = FILTER_BITS / 8;
  localparam int ROW_AW      = $clog2(STORE_BYTES);
  localparam int SEL_W       = $clog2(MAX_HASHES);
  localparam int FB_W        = 14;
  localparam int HC_W        = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 14;
  localparam int DIV_STEPS   = 4;
  localparam int DIV_CYCLES  = 32 / DIV_STEPS;
  localparam int DIV_CNT_W   = $clog2(DIV_CYCLES);

  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HASH_COUNT   = 2'd1;

  localparam logic [FB_W-1:0] FB_MAX = FB_W'(STORE_BYTES);
  localparam logic [HC_W-1:0] HC_MAX = HC_W'(MAX_HASHES);

  typedef struct packed {
    logic             take;
    logic             clr_wr;
    logic             div_load;
    logic             div_step;
    logic             rd_en;
    logic             upd;
    logic             finish;
    logic [SEL_W-1:0] sel;
  } cmd_t;

  typedef struct packed {
    logic            clr_done;
    logic            out_free;
    logic [HC_W-1:0] nhash;
  } sts_t;

  function automatic logic [31:0] prime(input logic [3:0] idx);
    logic [31:0] p;
    case (idx)
      4'd0:    p = 32'd486187739;
      4'd1:    p = 32'd92821;
      4'd2:    p = 32'd22375207;
      4'd3:    p = 32'd18544973;
      4'd4:    p = 32'd29226163;
      4'd5:    p = 32'd30696949;
      4'd6:    p = 32'd30709619;
      4'd7:    p = 32'd17818487;
      4'd8:    p = 32'd15762389;
      4'd9:    p = 32'd31501619;
      4'd10:   p = 32'd31623667;
      4'd11:   p = 32'd32452843;
      4'd12:   p = 32'd15486241;
      4'd13:   p = 32'd15489053;
      4'd14:   p = 32'd29684339;
      4'd15:   p = 32'd31074107;
      default: p = 32'd0;
    endcase
    return p;
  endfunction

  function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = a * b;
    return p[31:0];
  endfunction

  function automatic logic [31:0] start_value(input logic [3:0] v);
    return mul32(prime(v + 4'd1), prime(v + 4'd2));
  endfunction

endpackage

@@ src/bloom_filter_add_query.sv @@
// Bloom filter add/query top level: controller, datapath and byte-wide bit store.
// A non-last key byte is taken whenever the block is idle. With n = hash_count capped at 16,
// a last byte runs n probe variants, then raises out_valid and accepts the next request:
// per variant one load, the modulo steps (four remainder bits per cycle), one store read
// and one update or check. The result register frees the input side while a result waits.
// After reset every byte row of the store is cleared, one row a cycle, with in_stall high.
module bloom_filter_add_query (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bfaq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bfaq_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_mode,
  input  logic [7:0]                      in_key_byte,
  input  logic                            in_last,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_found,
  output logic                            out_was_query
);
  import bfaq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bfaq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_last),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bfaq_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_mode       (in_mode),
    .in_key_byte   (in_key_byte),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_found     (out_found),
    .out_was_query (out_was_query),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule

@@ src/bfaq_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module bfaq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ src/bfaq_ctrl.sv @@
// Controller state machine: clearing pass, byte intake, per-variant probe sequence.
module bfaq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_last,
  output logic          in_stall,
  input  bfaq_pkg::sts_t sts,
  output bfaq_pkg::cmd_t cmd
);
  import bfaq_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_RD    = 3'd4;
  localparam logic [2:0] S_UPD   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]           state_r, state_nxt;
  logic [SEL_W-1:0]     v_r, v_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    v_nxt        = v_r;
    cnt_nxt      = cnt_r;
    cmd          = '0;
    cmd.sel      = v_r;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.take = in_valid;
        if (in_valid && in_last) begin
          v_nxt = '0;
          if (sts.nhash == '0) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        cmd.div_load = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_CYCLES - 1)) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd = 1'b1;
        if (({1'b0, v_r} + 5'd1) == sts.nhash) begin
          state_nxt = S_DONE;
        end else begin
          v_nxt     = v_r + 1'b1;
          state_nxt = S_LOAD;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      v_r     <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      v_r     <= v_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

@@ src/bfaq_dp.sv @@
// Datapath: config registers, hash lanes, modulo unit, bit store and result register.
module bfaq_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bfaq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bfaq_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_mode,
  input  logic [7:0]                     in_key_byte,
  input  logic                           in_last,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_found,
  output logic                           out_was_query,
  input  bfaq_pkg::cmd_t                 cmd,
  output bfaq_pkg::sts_t                 sts
);
  import bfaq_pkg::*;

  logic [FB_W-1:0]   filter_bytes_r;
  logic [HC_W-1:0]   hash_count_r;
  logic [FB_W-1:0]   nbytes;
  logic [31:0]       hash_r [MAX_HASHES];
  logic [31:0]       lane_sel;
  logic [31:0]       q_r, q_nxt;
  logic [FB_W-1:0]   rem_r, rem_nxt;
  logic [2:0]        bitsel_r;
  logic              mode_r;
  logic              found_r;
  logic [ROW_AW-1:0] clr_addr_r;
  logic              ram_wr_en;
  logic [ROW_AW-1:0] ram_wr_addr;
  logic [7:0]        ram_wr_data;
  logic [7:0]        ram_rd_data;
  logic              out_valid_r;
  logic              out_found_r;
  logic              out_was_query_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_bytes_r <= FB_MAX;
      hash_count_r   <= HC_W'(3);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FILTER_BYTES: filter_bytes_r <= cfg_data[FB_W-1:0];
        CFG_HASH_COUNT:   hash_count_r   <= cfg_data[HC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (filter_bytes_r == '0) begin
      nbytes = FB_W'(1);
    end else if (filter_bytes_r > FB_MAX) begin
      nbytes = FB_MAX;
    end else begin
      nbytes = filter_bytes_r;
    end
  end

  assign sts.nhash = (hash_count_r > HC_MAX) ? HC_MAX : hash_count_r;

  always_ff @(posedge clk) begin
    for (int v = 0; v < MAX_HASHES; v++) begin
      if (!rst_n || cmd.finish) begin
        hash_r[v] <= start_value(4'(v));
      end else if (cmd.take) begin
        hash_r[v] <= mul32(hash_r[v] ^ {24'd0, in_key_byte}, prime(4'(v)));
      end
    end
  end

  assign lane_sel = hash_r[cmd.sel];

  always_comb begin
    logic [FB_W:0] r;
    logic [31:0]   q;
    r = {1'b0, rem_r};
    q = q_r;
    for (int i = 0; i < DIV_STEPS; i++) begin
      r = {r[FB_W-1:0], q[31]};
      q = {q[30:0], 1'b0};
      if (r >= {1'b0, nbytes}) begin
        r = r - {1'b0, nbytes};
      end
    end
    rem_nxt = r[FB_W-1:0];
    q_nxt   = q;
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      q_r      <= {3'd0, lane_sel[31:3]};
      rem_r    <= '0;
      bitsel_r <= lane_sel[2:0];
    end else if (cmd.div_step) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && in_last) begin
      mode_r  <= in_mode;
      found_r <= 1'b1;
    end else if (cmd.upd && mode_r && !ram_rd_data[bitsel_r]) begin
      found_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  assign sts.clr_done = (clr_addr_r == ROW_AW'(STORE_BYTES - 1));

  always_comb begin
    if (cmd.clr_wr) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = clr_addr_r;
      ram_wr_data = 8'd0;
    end else begin
      ram_wr_en   = cmd.upd && !mode_r;
      ram_wr_addr = rem_r[ROW_AW-1:0];
      ram_wr_data = ram_rd_data | (8'd1 << bitsel_r);
    end
  end

  bfaq_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (rem_r[ROW_AW-1:0]),
    .rd_data (ram_rd_data)
  );

  assign sts.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_found_r     <= mode_r ? found_r : 1'b1;
      out_was_query_r <= mode_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_found     = out_found_r;
  assign out_was_query = out_was_query_r;

endmodule

@@ src/bfaq_checker.sv @@
// Port-level assertions for the Bloom filter top level, bound to it.
module bfaq_checker (
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_found,
  input logic out_was_query
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_found) && $stable(out_was_query))
    else $error("stalled result changed");

  a_add_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_was_query |-> out_found)
    else $error("add result without found");

  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall && !out_valid)
    else $error("block not clearing after reset");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without key end processing");

endmodule

bind bloom_filter_add_query bfaq_checker u_bfaq_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_found     (out_found),
  .out_was_query (out_was_query)
);

@@ test/tb_bloom_filter_add_query.sv @@
// Self-checking testbench for the Bloom filter add/query block.
`timescale 1ns / 1ps

module tb_bloom_filter_add_query;
  import bfaq_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int SETTLE_CYCLES = 200;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 230;
  localparam int KNOWN_KEYS_MAX = 64;
  localparam logic MODE_ADD = 1'b0;
  localparam logic MODE_QUERY = 1'b1;
  localparam logic [FB_W-1:0] RESET_FILTER_BYTES = 14'd8192;
  localparam logic [HC_W-1:0] RESET_HASH_COUNT = 5'd3;

  localparam bit [31:0] HASH_PRIME [16] = '{
    32'd486187739, 32'd92821, 32'd22375207, 32'd18544973,
    32'd29226163, 32'd30696949, 32'd30709619, 32'd17818487,
    32'd15762389, 32'd31501619, 32'd31623667, 32'd32452843,
    32'd15486241, 32'd15489053, 32'd29684339, 32'd31074107
  };

  localparam logic [FB_W-1:0] PHASE_FBYTES [RANDOM_PHASES] = '{
    14'd8192, 14'd1, 14'd16383, 14'd0, 14'd64, 14'd1000, 14'd8191, 14'd5
  };
  localparam logic [HC_W-1:0] PHASE_HCOUNT [RANDOM_PHASES] = '{
    5'd3, 5'd16, 5'd31, 5'd0, 5'd1, 5'd7, 5'd2, 5'd16
  };
  localparam int PHASE_IDLE [4] = '{0, 45, 0, 29};
  localparam int PHASE_STALL [4] = '{0, 0, 45, 29};

  typedef struct packed {
    logic found;
    logic was_query;
  } answer_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic                  mode;
    logic [7:0]            key_byte;
    logic                  last;
    logic                  typed;
    logic                  exp_found;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
  } row_t;

  typedef struct {
    logic [95:0] bytes;
    int          len;
  } key_rec_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_mode = 1'b0;
  logic [7:0]            in_key_byte = 8'd0;
  logic                  in_last = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_found;
  logic                  out_was_query;

  bit              filter_store [FILTER_BITS];
  logic [31:0]     key_hash [MAX_HASHES];
  logic [FB_W-1:0] cur_fbytes;
  logic [HC_W-1:0] cur_hcount;

  answer_t  pending_answers [$];
  row_t     script [$];
  key_rec_t known_keys [$];
  int       mismatch_count = 0;
  int       cycle_count = 0;
  int       idle_pct = 0;
  int       stall_pct = 0;

  bloom_filter_add_query DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_key_byte   (in_key_byte),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_found     (out_found),
    .out_was_query (out_was_query)
  );

  always #10 clk = ~clk;

  function automatic void restart_hashes();
    for (int v = 0; v < MAX_HASHES; v++) begin
      key_hash[v] = HASH_PRIME[(v + 1) % 16] * HASH_PRIME[(v + 2) % 16];
    end
  endfunction

  function automatic bit bloom_lookup(input logic mode, input logic [7:0] kb,
                                      input logic last, output answer_t ans);
    logic [31:0] nbytes;
    logic [31:0] modulus;
    logic [31:0] bit_idx;
    int          nhash;
    logic        all_set;
    ans = '0;
    for (int v = 0; v < MAX_HASHES; v++) begin
      key_hash[v] = (key_hash[v] ^ {24'd0, kb}) * HASH_PRIME[v];
    end
    if (!last) begin
      return 1'b0;
    end
    nbytes = (cur_fbytes == 0) ? 32'd1 : 32'(cur_fbytes);
    if (nbytes > STORE_BYTES) begin
      nbytes = STORE_BYTES;
    end
    nhash = (cur_hcount > MAX_HASHES) ? MAX_HASHES : int'(cur_hcount);
    modulus = nbytes * 8;
    all_set = 1'b1;
    for (int v = 0; v < nhash; v++) begin
      bit_idx = key_hash[v] % modulus;
      if (mode == MODE_ADD) begin
        filter_store[bit_idx] = 1'b1;
      end else if (!filter_store[bit_idx]) begin
        all_set = 1'b0;
      end
    end
    restart_hashes();
    ans.found = (mode == MODE_ADD) ? 1'b1 : all_set;
    ans.was_query = mode;
    return 1'b1;
  endfunction

  function automatic void item_row(input logic mode, input logic [7:0] kb, input logic last);
    script.push_back('{ROW_ITEM, mode, kb, last, 1'b0, 1'b0, '0, '0});
  endfunction

  function automatic void typed_row(input logic mode, input logic [7:0] kb,
                                    input logic exp_found);
    script.push_back('{ROW_ITEM, mode, kb, 1'b1, 1'b1, exp_found, '0, '0});
  endfunction

  function automatic void reg_row(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
    script.push_back('{ROW_REG, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0, idx, val});
  endfunction

  task automatic send_item(input logic mode, input logic [7:0] kb, input logic last,
                           input logic typed, input logic exp_found);
    answer_t ans;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_key_byte <= kb;
    in_last <= last;
    do @(posedge clk); while (in_stall);
    if (bloom_lookup(mode, kb, last, ans)) begin
      if (typed) begin
        ans.found = exp_found;
      end
      pending_answers.push_back(ans);
    end
  endtask

  task automatic wait_answers();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_answers.size() != 0);
  endtask

  task automatic settle();
    wait_answers();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val, input bit more);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (!more) begin
      cfg_valid <= 1'b0;
    end
    if (idx == CFG_FILTER_BYTES) begin
      cur_fbytes = val[FB_W-1:0];
    end else if (idx == CFG_HASH_COUNT) begin
      cur_hcount = val[HC_W-1:0];
    end
  endtask

  task automatic send_random_key(inout int sent);
    key_rec_t k;
    int       choice;
    logic     mode;
    choice = $urandom_range(99);
    if (choice < 35 && known_keys.size() > 0) begin
      k = known_keys[$urandom_range(known_keys.size() - 1)];
      mode = MODE_QUERY;
    end else begin
      k.len = ($urandom_range(9) == 0) ? $urandom_range(12, 5) : $urandom_range(4, 1);
      k.bytes = {$urandom, $urandom, $urandom};
      mode = (choice < 75) ? MODE_ADD : MODE_QUERY;
      if (mode == MODE_ADD) begin
        known_keys.push_back(k);
        if (known_keys.size() > KNOWN_KEYS_MAX) begin
          void'(known_keys.pop_front());
        end
      end
    end
    if ($urandom_range(29) == 0) begin
      wait_answers();
    end
    for (int i = 0; i < k.len; i++) begin
      send_item((i == k.len - 1) ? mode : logic'($urandom_range(1)),
                k.bytes[i*8 +: 8], i == k.len - 1, 1'b0, 1'b0);
    end
    sent += k.len;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("bloom_filter_add_query regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    answer_t exp_ans;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result found=%0b was_query=%0b",
                 $time, out_found, out_was_query);
        mismatch_count++;
      end else begin
        exp_ans = pending_answers.pop_front();
        if (out_found !== exp_ans.found) begin
          $display("%0t: found expected %0b actual %0b", $time, exp_ans.found, out_found);
          mismatch_count++;
        end
        if (out_was_query !== exp_ans.was_query) begin
          $display("%0t: was_query expected %0b actual %0b",
                   $time, exp_ans.was_query, out_was_query);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int sent;
    restart_hashes();
    cur_fbytes = RESET_FILTER_BYTES;
    cur_hcount = RESET_HASH_COUNT;

    typed_row(MODE_QUERY, 8'h00, 1'b0);
    typed_row(MODE_ADD, 8'hFF, 1'b1);
    typed_row(MODE_QUERY, 8'hFF, 1'b1);
    item_row(MODE_QUERY, 8'h00, 1'b0);
    item_row(MODE_QUERY, 8'h55, 1'b0);
    typed_row(MODE_ADD, 8'hAA, 1'b1);
    item_row(MODE_ADD, 8'h00, 1'b0);
    item_row(MODE_ADD, 8'h55, 1'b0);
    typed_row(MODE_QUERY, 8'hAA, 1'b1);
    item_row(MODE_QUERY, 8'h80, 1'b1);
    reg_row(CFG_HASH_COUNT, 14'd0);
    typed_row(MODE_QUERY, 8'h01, 1'b1);
    typed_row(MODE_ADD, 8'h02, 1'b1);
    reg_row(CFG_FILTER_BYTES, 14'd0);
    reg_row(CFG_HASH_COUNT, 14'd31);
    typed_row(MODE_ADD, 8'h03, 1'b1);
    typed_row(MODE_QUERY, 8'h03, 1'b1);
    item_row(MODE_QUERY, 8'h7F, 1'b1);
    reg_row(CFG_FILTER_BYTES, 14'd16383);
    reg_row(CFG_HASH_COUNT, 14'd16);
    item_row(MODE_ADD, 8'h10, 1'b0);
    reg_row(CFG_HASH_COUNT, 14'd1);
    item_row(MODE_QUERY, 8'h20, 1'b1);
    reg_row(CFG_FILTER_BYTES, 14'd1);
    item_row(MODE_ADD, 8'h00, 1'b1);
    item_row(MODE_QUERY, 8'hC3, 1'b1);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].kind == ROW_REG) begin
        if (i == 0 || script[i-1].kind != ROW_REG) begin
          settle();
        end
        write_reg(script[i].reg_idx, script[i].reg_val,
                  i + 1 < script.size() && script[i+1].kind == ROW_REG);
      end else begin
        send_item(script[i].mode, script[i].key_byte, script[i].last,
                  script[i].typed, script[i].exp_found);
      end
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      write_reg(CFG_FILTER_BYTES, PHASE_FBYTES[ph], 1'b1);
      write_reg(CFG_HASH_COUNT, CFG_DATA_W'(PHASE_HCOUNT[ph]), 1'b0);
      idle_pct = PHASE_IDLE[ph % 4];
      stall_pct = PHASE_STALL[ph % 4];
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        send_random_key(sent);
      end
    end

    settle();
    if (mismatch_count == 0 && pending_answers.size() == 0) begin
      $display("bloom_filter_add_query regression: pass");
    end else begin
      $display("bloom_filter_add_query regression: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/bfaq_pkg.sv
src/bfaq_ram.sv
src/bfaq_ctrl.sv
src/bfaq_dp.sv
src/bloom_filter_add_query.sv
src/bfaq_checker.sv
test/tb_bloom_filter_add_query.sv
